// ----- hdl/brd_pkg.sv -----
// ----------------------------------------------------------------------------
// brd_pkg
// Types, constants and helpers shared by the bracketed Brent root finder.
// ----------------------------------------------------------------------------
package brd_pkg;

   localparam int PT_W    = 32;   // point, signed Q2.30
   localparam int VAL_W   = 32;   // value, signed Q16.16
   localparam int FAC_W   = 33;   // one factor of a product term
   localparam int MAG_W   = 32;   // magnitude of a factor
   localparam int WIDE_W  = 128;  // numerator, denominator, products
   localparam int CNT_W   = 11;
   localparam int TOL_W   = 31;
   localparam int MAXIT_W = 10;

   localparam logic [PT_W-1:0] PT_ONE = 32'h4000_0000;
   localparam logic [PT_W-1:0] PT_MAX = 32'h7fff_ffff;
   localparam logic [PT_W-1:0] PT_MIN = 32'h8000_0000;
   localparam logic [PT_W-1:0] PT_NEG_ONE = 32'hc000_0000;

   localparam logic REQ_START = 1'b0;
   localparam logic REQ_VALUE = 1'b1;

   localparam logic CSR_TOLERANCE = 1'b0;
   localparam logic CSR_MAX_ITER  = 1'b1;

   typedef enum logic [1:0] {
      PH_IDLE  = 2'd0,
      PH_WANT0 = 2'd1,
      PH_WANT1 = 2'd2,
      PH_WANTS = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      TERM_N0  = 2'd0,
      TERM_N1  = 2'd1,
      TERM_N2  = 2'd2,
      TERM_DEN = 2'd3
   } term_type;

   typedef struct packed {
      logic              start;
      logic [WIDE_W-1:0] num;
      logic [WIDE_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic             finished;
      logic [PT_W-1:0]  point;
      logic [CNT_W-1:0] count;
      logic             status;
   } result_type;

   function automatic logic [FAC_W-1:0] mag33(input logic signed [FAC_W-1:0] x);
      mag33 = x[FAC_W-1] ? FAC_W'(-x) : FAC_W'(x);
   endfunction

   function automatic logic same_sign(input logic signed [VAL_W-1:0] a,
                                      input logic signed [VAL_W-1:0] b);
      same_sign = (a > 0 && b > 0) || (a < 0 && b < 0);
   endfunction

endpackage

// ----- hdl/brd_div.sv -----
// ----------------------------------------------------------------------------
// brd_div
// Unsigned 128 by 128 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module brd_div (
   input  logic                 clock,
   input  logic                 reset,
   input  brd_pkg::div_req_type div_req,
   output logic                 div_done,
   output logic [127:0]         div_quo
);
   import brd_pkg::*;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [6:0]        cnt_ff, cnt_in;
   logic [WIDE_W:0]   rem_ff, rem_in;
   logic [WIDE_W-1:0] num_ff, num_in;
   logic [WIDE_W-1:0] den_ff, den_in;
   logic [WIDE_W-1:0] quo_ff, quo_in;
   logic [WIDE_W:0]   rem_sh;
   logic              fits;

   assign rem_sh = {rem_ff[WIDE_W-1:0], num_ff[WIDE_W-1]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         num_in  = div_req.num;
         den_in  = div_req.den;
      end else if (busy_ff) begin
         rem_in = fits ? rem_sh - {1'b0, den_ff} : rem_sh;
         quo_in = {quo_ff[WIDE_W-2:0], fits};
         num_in = {num_ff[WIDE_W-2:0], 1'b0};
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_done = done_ff;
   assign div_quo  = quo_ff;

endmodule

// ----- hdl/bracketed_root_brent_core.sv -----
// ----------------------------------------------------------------------------
// bracketed_root_brent_core
// Brent root finder on [0,1]: issues query points, takes function values.
// ----------------------------------------------------------------------------
// Start and endpoint requests, and a no-bracket result, go from idle straight to emit; a final
// root passes through order and advance first. An interpolation step (inverse quadratic or
// secant) runs each product factor through the shared shift-add multiplier, then the divider.
// One request at a time; req_ready is low while a step is computed.
// A finished result waits in the output register while the next request is taken.
// Synchronous reset: tolerance 1024, max_iterations 100, phase idle, no result.
module bracketed_root_brent_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [31:0] req_func_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_finished,
   output logic [31:0] rsp_point,
   output logic [10:0] rsp_iteration_count,
   output logic        rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [30:0] csr_data
);
   import brd_pkg::*;

   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_ORDER   = 11'b000_0000_0010,
      S_ADV     = 11'b000_0000_0100,
      S_TLOAD   = 11'b000_0000_1000,
      S_MLOAD   = 11'b000_0001_0000,
      S_MUL     = 11'b000_0010_0000,
      S_ACC     = 11'b000_0100_0000,
      S_DIV     = 11'b000_1000_0000,
      S_DIVWAIT = 11'b001_0000_0000,
      S_TEST    = 11'b010_0000_0000,
      S_EMIT    = 11'b100_0000_0000
   } state_type;

   state_type state_ff, state_in;
   phase_type ph_ff, ph_in;
   term_type  ti_ff, ti_in;

   logic signed [PT_W-1:0]  cp_ff, cp_in, bp_ff, bp_in, pp_ff, pp_in, op_ff, op_in;
   logic signed [PT_W-1:0]  pend_ff, pend_in, s_ff, s_in;
   logic signed [VAL_W-1:0] cv_ff, cv_in, bv_ff, bv_in, pv_ff, pv_in;
   logic                    bis_ff, bis_in, ok_ff, ok_in, iqi_ff, iqi_in;
   logic                    setprev_ff, setprev_in, pneg_ff, pneg_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic [TOL_W-1:0]        tol_ff, tol_in;
   logic [MAXIT_W-1:0]      maxit_ff, maxit_in;
   logic [1:0]              fi_ff, fi_in;
   logic [4:0]              mcnt_ff, mcnt_in;
   logic [WIDE_W-1:0]       prod_ff, prod_in, mcand_ff, mcand_in, acc_ff, acc_in;
   logic [WIDE_W-1:0]       num_ff, num_in, den_ff, den_in;
   logic [MAG_W-1:0]        mplier_ff, mplier_in;
   result_type              res_ff, res_in, out_ff, out_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   div_req_type             div_req;
   logic                    div_done;
   logic [WIDE_W-1:0]       div_quo;

   logic signed [VAL_W-1:0] g;
   logic signed [FAC_W-1:0] fac, dab, dac, dbc, dba;
   logic [FAC_W-1:0]        fac_mag;
   logic [WIDE_W-1:0]       mul_sum, term_val, num_mag, den_mag;
   logic signed [PT_W-1:0]  s_q;
   logic [FAC_W-1:0]        cv_mag, bv_mag, width_ab;
   logic                    swap, far, at_limit;
   logic signed [PT_W-1:0]  cp_o, bp_o;
   logic signed [VAL_W-1:0] cv_o, bv_o;
   logic signed [35:0]      u_val, sa36, sb36, s36;
   logic signed [FAC_W-1:0] v_val, d_sb, sum_ab, sum_rnd, half_ab;
   logic [33:0]             dsb;
   logic [FAC_W-1:0]        abs_bc, abs_co;
   logic                    t1, t2, t3, use_bis;
   logic signed [PT_W-1:0]  s_sel;

   brd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_done (div_done),
      .div_quo  (div_quo)
   );

   assign g = req_func_value;

   assign dab = FAC_W'(cv_ff) - FAC_W'(bv_ff);
   assign dac = FAC_W'(cv_ff) - FAC_W'(pv_ff);
   assign dbc = FAC_W'(bv_ff) - FAC_W'(pv_ff);
   assign dba = FAC_W'(bv_ff) - FAC_W'(cv_ff);

   // factor table: numerator terms and denominator, unused slots are one
   always_comb begin
      fac = FAC_W'(1);
      if (iqi_ff) begin
         unique case (ti_ff)
            TERM_N0: unique case (fi_ff)
               2'd0: fac = FAC_W'(cp_ff);
               2'd1: fac = FAC_W'(bv_ff);
               2'd2: fac = FAC_W'(pv_ff);
               2'd3: fac = dbc;
            endcase
            TERM_N1: unique case (fi_ff)
               2'd0: fac = FAC_W'(bp_ff);
               2'd1: fac = FAC_W'(cv_ff);
               2'd2: fac = FAC_W'(pv_ff);
               2'd3: fac = dac;
            endcase
            TERM_N2: unique case (fi_ff)
               2'd0: fac = FAC_W'(pp_ff);
               2'd1: fac = FAC_W'(cv_ff);
               2'd2: fac = FAC_W'(bv_ff);
               2'd3: fac = dab;
            endcase
            TERM_DEN: unique case (fi_ff)
               2'd0: fac = dab;
               2'd1: fac = dac;
               2'd2: fac = dbc;
               2'd3: fac = FAC_W'(1);
            endcase
         endcase
      end else begin
         unique case (ti_ff)
            TERM_N0:  fac = (fi_ff == 2'd0) ? FAC_W'(cp_ff) :
                            (fi_ff == 2'd1) ? FAC_W'(bv_ff) : FAC_W'(1);
            TERM_N1:  fac = (fi_ff == 2'd0) ? FAC_W'(bp_ff) :
                            (fi_ff == 2'd1) ? FAC_W'(cv_ff) : FAC_W'(1);
            TERM_N2:  fac = FAC_W'(1);
            TERM_DEN: fac = (fi_ff == 2'd0) ? dba : FAC_W'(1);
         endcase
      end
   end

   assign fac_mag  = mag33(fac);
   assign mul_sum  = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
   assign term_val = pneg_ff ? WIDE_W'(0) - prod_ff : prod_ff;
   assign num_mag  = num_ff[WIDE_W-1] ? WIDE_W'(0) - num_ff : num_ff;
   assign den_mag  = den_ff[WIDE_W-1] ? WIDE_W'(0) - den_ff : den_ff;

   // saturate the truncated quotient to the point range
   always_comb begin
      if (num_ff[WIDE_W-1] ^ den_ff[WIDE_W-1]) begin
         if (div_quo > WIDE_W'(PT_MIN)) s_q = PT_MIN;
         else                           s_q = PT_W'(0) - div_quo[PT_W-1:0];
      end else begin
         if (div_quo > WIDE_W'(PT_MAX)) s_q = PT_MAX;
         else                           s_q = div_quo[PT_W-1:0];
      end
   end

   // keep the smaller value as best
   assign cv_mag = mag33(FAC_W'(cv_ff));
   assign bv_mag = mag33(FAC_W'(bv_ff));
   assign swap   = cv_mag < bv_mag;
   assign cp_o   = swap ? bp_ff : cp_ff;
   assign bp_o   = swap ? cp_ff : bp_ff;
   assign cv_o   = swap ? bv_ff : cv_ff;
   assign bv_o   = swap ? cv_ff : bv_ff;

   assign width_ab = mag33(FAC_W'(bp_ff) - FAC_W'(cp_ff));
   assign far      = width_ab > {2'b0, tol_ff};
   assign at_limit = step_ff >= {1'b0, maxit_ff};

   // Brent acceptance tests
   assign sa36    = 36'(cp_ff);
   assign sb36    = 36'(bp_ff);
   assign s36     = 36'(s_ff);
   assign u_val   = (sa36 <<< 1) + sa36 + sb36 - (s36 <<< 2);
   assign v_val   = FAC_W'(bp_ff) - FAC_W'(s_ff);
   assign t1      = (u_val != 0) && (v_val != 0) && (u_val[35] == v_val[FAC_W-1]);
   assign d_sb    = FAC_W'(s_ff) - FAC_W'(bp_ff);
   assign dsb     = {mag33(d_sb), 1'b0};
   assign abs_bc  = mag33(FAC_W'(bp_ff) - FAC_W'(pp_ff));
   assign abs_co  = mag33(FAC_W'(pp_ff) - FAC_W'(op_ff));
   assign t2      = bis_ff && (dsb >= {1'b0, abs_bc});
   assign t3      = !bis_ff && (dsb >= {1'b0, abs_co});
   assign use_bis = !ok_ff || t1 || t2 || t3;
   assign sum_ab  = FAC_W'(cp_ff) + FAC_W'(bp_ff);
   assign sum_rnd = sum_ab + $signed({{(FAC_W-1){1'b0}}, sum_ab[FAC_W-1]});
   assign half_ab = sum_rnd >>> 1;   // toward zero
   assign s_sel   = use_bis ? half_ab[PT_W-1:0] : s_ff;

   always_comb begin
      state_in     = state_ff;
      ph_in        = ph_ff;
      ti_in        = ti_ff;
      cp_in        = cp_ff;
      bp_in        = bp_ff;
      pp_in        = pp_ff;
      op_in        = op_ff;
      pend_in      = pend_ff;
      s_in         = s_ff;
      cv_in        = cv_ff;
      bv_in        = bv_ff;
      pv_in        = pv_ff;
      bis_in       = bis_ff;
      ok_in        = ok_ff;
      iqi_in       = iqi_ff;
      setprev_in   = setprev_ff;
      pneg_in      = pneg_ff;
      step_in      = step_ff;
      tol_in       = tol_ff;
      maxit_in     = maxit_ff;
      fi_in        = fi_ff;
      mcnt_in      = mcnt_ff;
      prod_in      = prod_ff;
      mcand_in     = mcand_ff;
      acc_in       = acc_ff;
      mplier_in    = mplier_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      res_in       = res_ff;
      out_in       = out_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_req      = '0;

      if (csr_valid) begin
         unique case (csr_index)
            CSR_TOLERANCE: tol_in   = csr_data;
            CSR_MAX_ITER:  maxit_in = csr_data[MAXIT_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: if (req_valid) begin
            if (req_type == REQ_START) begin
               ph_in    = PH_WANT0;
               step_in  = '0;
               bis_in   = 1'b1;
               res_in   = '{finished: 1'b0, point: '0, count: '0, status: 1'b0};
               state_in = S_EMIT;
            end else begin
               unique case (ph_ff)
                  PH_WANT0: begin
                     cp_in    = '0;
                     cv_in    = g;
                     ph_in    = PH_WANT1;
                     res_in   = '{finished: 1'b0, point: PT_ONE, count: '0, status: 1'b0};
                     state_in = S_EMIT;
                  end
                  PH_WANT1: begin
                     bp_in = PT_ONE;
                     bv_in = g;
                     if (same_sign(cv_ff, g)) begin
                        ph_in    = PH_IDLE;
                        res_in   = '{finished: 1'b1, point: PT_NEG_ONE, count: '0,
                                     status: 1'b1};
                        state_in = S_EMIT;
                     end else begin
                        setprev_in = 1'b1;
                        bis_in     = 1'b1;
                        step_in    = '0;
                        state_in   = S_ORDER;
                     end
                  end
                  PH_WANTS: begin
                     op_in = pp_ff;
                     pp_in = bp_ff;
                     pv_in = bv_ff;
                     if (same_sign(cv_ff, g)) begin
                        cp_in = pend_ff;
                        cv_in = g;
                     end else begin
                        bp_in = pend_ff;
                        bv_in = g;
                     end
                     setprev_in = 1'b0;
                     state_in   = S_ORDER;
                  end
                  PH_IDLE: state_in = S_IDLE;   // stray value is dropped
               endcase
            end
         end
         S_ORDER: begin
            cp_in = cp_o;
            bp_in = bp_o;
            cv_in = cv_o;
            bv_in = bv_o;
            if (setprev_ff) begin
               pp_in = cp_o;
               pv_in = cv_o;
               op_in = cp_o;
            end
            state_in = S_ADV;
         end
         S_ADV: begin
            if (bv_ff == 0 || !far || at_limit) begin
               ph_in    = PH_IDLE;
               res_in   = '{finished: 1'b1, point: bp_ff,
                            count: step_ff + CNT_W'(bv_ff != 0 && far), status: 1'b0};
               state_in = S_EMIT;
            end else begin
               step_in  = step_ff + CNT_W'(1);
               iqi_in   = (cv_ff != pv_ff) && (bv_ff != pv_ff);
               ti_in    = TERM_N0;
               fi_in    = 2'd0;
               num_in   = '0;
               state_in = S_TLOAD;
            end
         end
         S_TLOAD: begin
            prod_in  = WIDE_W'(fac_mag[MAG_W-1:0]);
            pneg_in  = fac[FAC_W-1];
            fi_in    = 2'd1;
            state_in = S_MLOAD;
         end
         S_MLOAD: begin
            mcand_in  = prod_ff;
            acc_in    = '0;
            mplier_in = fac_mag[MAG_W-1:0];
            pneg_in   = pneg_ff ^ fac[FAC_W-1];
            mcnt_in   = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            acc_in    = mul_sum;
            mcand_in  = {mcand_ff[WIDE_W-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[MAG_W-1:1]};
            mcnt_in   = mcnt_ff + 5'd1;
            if (mcnt_ff == 5'd31) begin
               prod_in = mul_sum;
               if (fi_ff == 2'd3) begin
                  state_in = S_ACC;
               end else begin
                  fi_in    = fi_ff + 2'd1;
                  state_in = S_MLOAD;
               end
            end
         end
         S_ACC: begin
            fi_in = 2'd0;
            unique case (ti_ff)
               TERM_N0: begin
                  num_in   = num_ff + term_val;
                  ti_in    = TERM_N1;
                  state_in = S_TLOAD;
               end
               TERM_N1: begin
                  num_in   = num_ff - term_val;
                  ti_in    = iqi_ff ? TERM_N2 : TERM_DEN;
                  state_in = S_TLOAD;
               end
               TERM_N2: begin
                  num_in   = num_ff + term_val;
                  ti_in    = TERM_DEN;
                  state_in = S_TLOAD;
               end
               TERM_DEN: begin
                  den_in   = term_val;
                  state_in = S_DIV;
               end
            endcase
         end
         S_DIV: begin
            if (den_ff == '0) begin
               ok_in    = 1'b0;
               state_in = S_TEST;
            end else begin
               div_req.start = 1'b1;
               div_req.num   = num_mag;
               div_req.den   = den_mag;
               state_in      = S_DIVWAIT;
            end
         end
         S_DIVWAIT: if (div_done) begin
            s_in     = s_q;
            ok_in    = 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            bis_in   = use_bis;
            pend_in  = s_sel;
            ph_in    = PH_WANTS;
            res_in   = '{finished: 1'b0, point: s_sel, count: '0, status: 1'b0};
            state_in = S_EMIT;
         end
         S_EMIT: if (!rsp_valid_ff || rsp_ready) begin
            rsp_valid_in = 1'b1;
            out_in       = res_ff;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         ph_ff        <= PH_IDLE;
         cp_ff        <= '0;
         bp_ff        <= '0;
         pp_ff        <= '0;
         op_ff        <= '0;
         pend_ff      <= '0;
         cv_ff        <= '0;
         bv_ff        <= '0;
         pv_ff        <= '0;
         bis_ff       <= 1'b1;
         step_ff      <= '0;
         tol_ff       <= TOL_W'(1024);
         maxit_ff     <= MAXIT_W'(100);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ph_ff        <= ph_in;
         cp_ff        <= cp_in;
         bp_ff        <= bp_in;
         pp_ff        <= pp_in;
         op_ff        <= op_in;
         pend_ff      <= pend_in;
         cv_ff        <= cv_in;
         bv_ff        <= bv_in;
         pv_ff        <= pv_in;
         bis_ff       <= bis_in;
         step_ff      <= step_in;
         tol_ff       <= tol_in;
         maxit_ff     <= maxit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      ti_ff      <= ti_in;
      s_ff       <= s_in;
      ok_ff      <= ok_in;
      iqi_ff     <= iqi_in;
      setprev_ff <= setprev_in;
      pneg_ff    <= pneg_in;
      fi_ff      <= fi_in;
      mcnt_ff    <= mcnt_in;
      prod_ff    <= prod_in;
      mcand_ff   <= mcand_in;
      acc_ff     <= acc_in;
      mplier_ff  <= mplier_in;
      num_ff     <= num_in;
      den_ff     <= den_in;
      res_ff     <= res_in;
      out_ff     <= out_in;
   end

   assign req_ready           = (state_ff == S_IDLE);
   assign csr_ready           = 1'b1;
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_finished        = out_ff.finished;
   assign rsp_point           = out_ff.point;
   assign rsp_iteration_count = out_ff.count;
   assign rsp_status          = out_ff.status;

   a_final_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && (!rsp_valid_ff || rsp_ready) && res_ff.finished)
      |=> (ph_ff == PH_IDLE))
      else $error("final result left phase active");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == S_DIVWAIT))
      else $error("divider finished outside wait state");

   a_zero_den: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_TEST && !ok_ff) |=> bis_ff)
      else $error("zero denominator did not bisect");

   a_mul_factor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> (fi_ff != 2'd0))
      else $error("multiply on the leading factor");

endmodule

// ----- verif/tb_bracketed_root_brent_core.sv -----
// ----------------------------------------------------------------------------
// tb_bracketed_root_brent_core
// Drives whole root-finding solves through the core and checks every result
// against a fixed-point Brent predictor, over several tolerance and
// iteration-limit settings, with random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_bracketed_root_brent_core;
   timeunit 1ns;
   timeprecision 1ps;
   import brd_pkg::*;

   localparam int WATCHDOG_LIMIT = 40000;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef struct {
      logic        kind;
      logic [31:0] value;
      bit          typed;
      result_type  res;
   } stim_row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_type;
   logic [31:0] req_func_value;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_finished;
   logic [31:0] rsp_point;
   logic [10:0] rsp_iteration_count;
   logic        rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [30:0] csr_data;

   result_type  expected_q[$];
   int          fail_count;
   int          request_count;
   int          result_count;
   int          solve_count;
   int          idle_cycles;

   // solver copy kept by the predictor
   phase_type   ph;
   longint      ctr_pt, best_pt, prev_pt, old_pt, pend_pt;
   longint      ctr_val, best_val, prev_val;
   bit          bis_flag;
   longint      steps;
   longint      tol_reg, maxit_reg;

   bracketed_root_brent_core dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_func_value(req_func_value),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_finished(rsp_finished),
      .rsp_point(rsp_point), .rsp_iteration_count(rsp_iteration_count),
      .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic longint mag(longint x);
      return x < 0 ? -x : x;
   endfunction

   function automatic wide_type widen(longint x);
      wide_type w;
      w = x;
      return w;
   endfunction

   function automatic bit same_side(longint a, longint b);
      return (a > 0 && b > 0) || (a < 0 && b < 0);
   endfunction

   function automatic void set_res(output result_type r, input logic fin,
                                   input longint pt, input longint cnt, input logic st);
      r.finished = fin;
      r.point    = pt[31:0];
      r.count    = cnt[10:0];
      r.status   = st;
   endfunction

   // one Brent step: final root or next query point
   function automatic void brent_step(output result_type r);
      longint   sa, sb, sc, ga, gb, gc, s, u, v, dsb, span;
      wide_type n, d, q;
      bit       ok, t1, t2, t3;
      sa = ctr_pt;  sb = best_pt;  sc = prev_pt;
      ga = ctr_val; gb = best_val; gc = prev_val;
      span = mag(sb - sa);
      if (gb == 0 || span <= tol_reg || steps >= maxit_reg) begin
         if (gb != 0 && span > tol_reg)
            steps++;
         ph = PH_IDLE;
         set_res(r, 1'b1, sb, steps, 1'b0);
         return;
      end
      steps++;
      if (ga != gc && gb != gc) begin
         n = widen(sa) * widen(gb) * widen(gc) * widen(gb - gc)
           - widen(sb) * widen(ga) * widen(gc) * widen(ga - gc)
           + widen(sc) * widen(ga) * widen(gb) * widen(ga - gb);
         d = widen(ga - gb) * widen(ga - gc) * widen(gb - gc);
      end else begin
         n = widen(sa) * widen(gb) - widen(sb) * widen(ga);
         d = widen(gb - ga);
      end
      ok = (d != 0);
      s = 0;
      if (ok) begin
         q = n / d;
         if (q > widen(64'sd2147483647))
            s = 64'sd2147483647;
         else if (q < widen(-64'sd2147483648))
            s = -64'sd2147483648;
         else
            s = longint'(q);
      end
      u   = 3 * sa + sb - 4 * s;
      v   = sb - s;
      t1  = (u > 0 && v > 0) || (u < 0 && v < 0);
      dsb = 2 * mag(s - sb);
      t2  = bis_flag && dsb >= mag(sb - sc);
      t3  = !bis_flag && dsb >= mag(sc - old_pt);
      if (!ok || t1 || t2 || t3) begin
         s = (sa + sb) / 2;
         bis_flag = 1'b1;
      end else begin
         bis_flag = 1'b0;
      end
      pend_pt = s;
      ph = PH_WANTS;
      set_res(r, 1'b0, s, 0, 1'b0);
   endfunction

   function automatic void keep_best_smaller();
      longint t;
      if (mag(ctr_val) < mag(best_val)) begin
         t = ctr_val; ctr_val = best_val; best_val = t;
         t = ctr_pt;  ctr_pt = best_pt;   best_pt = t;
      end
   endfunction

   // returns 1 when the request produces a result
   function automatic bit predict_solver(input logic kind, input logic [31:0] fv,
                                         output result_type r);
      longint g;
      g = longint'(signed'(fv));
      r = '0;
      if (kind == REQ_START) begin
         ph = PH_WANT0;
         steps = 0;
         bis_flag = 1'b1;
         set_res(r, 1'b0, 0, 0, 1'b0);
         return 1'b1;
      end
      case (ph)
         PH_WANT0: begin
            ctr_pt = 0;
            ctr_val = g;
            ph = PH_WANT1;
            set_res(r, 1'b0, longint'(PT_ONE), 0, 1'b0);
         end
         PH_WANT1: begin
            best_pt = longint'(PT_ONE);
            best_val = g;
            if (same_side(ctr_val, g)) begin
               ph = PH_IDLE;
               set_res(r, 1'b1, -longint'(PT_ONE), 0, 1'b1);
            end else begin
               keep_best_smaller();
               prev_pt = ctr_pt;
               prev_val = ctr_val;
               old_pt = prev_pt;
               bis_flag = 1'b1;
               steps = 0;
               brent_step(r);
            end
         end
         PH_WANTS: begin
            old_pt = prev_pt;
            prev_pt = best_pt;
            prev_val = best_val;
            if (same_side(ctr_val, g)) begin
               ctr_pt = pend_pt;
               ctr_val = g;
            end else begin
               best_pt = pend_pt;
               best_val = g;
            end
            keep_best_smaller();
            brent_step(r);
         end
         default: return 1'b0;
      endcase
      return 1'b1;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 50) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_request(input logic kind, input logic [31:0] fv, input bit typed,
                               input result_type typed_res, output bit has,
                               output result_type r);
      int gap;
      req_type <= kind;
      req_func_value <= fv;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      request_count++;
      has = predict_solver(kind, fv, r);
      if (typed)
         r = typed_res;
      if (has)
         expected_q.push_back(r);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic write_csr(input logic idx, input logic [30:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_TOLERANCE)
         tol_reg = data;
      else
         maxit_reg = data[9:0];
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_q.size() != 0)
         @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   // test function value at a Q2.30 point, clamped to Q16.16
   function automatic logic [31:0] func_at(longint x, int shape, longint root,
                                           longint slope, bit flip);
      longint dx, y;
      dx = x - root;
      case (shape)
         0: y = (dx * slope) >>> 30;
         1: y = ((((dx * dx) >>> 30) * dx) >>> 30) * slope >>> 24;
         default: y = longint'(signed'(32'($urandom)));
      endcase
      if (flip)
         y = -y;
      if (y > 64'sd2147483647) y = 64'sd2147483647;
      if (y < -64'sd2147483648) y = -64'sd2147483648;
      return y[31:0];
   endfunction

   task automatic run_solve();
      int          shape, limit, k;
      longint      root, slope;
      bit          flip, has;
      result_type  r;
      logic [31:0] fv;
      shape = $urandom_range(0, 9) < 7 ? $urandom_range(0, 1) : 2;
      root  = $urandom_range(0, 9) == 0 ? longint'($urandom_range(0, 3)) * 32'h2000_0000
                                        : longint'($urandom_range(0, 32'h4000_0000));
      if ($urandom_range(0, 9) == 0)
         root = 64'sd1610612736;   // outside [0,1]: no bracket
      slope = $urandom_range(0, 3) == 0 ? longint'($urandom_range(1, 16))
                                        : longint'($urandom_range(1, 1 << 24));
      flip  = $urandom_range(0, 1);
      limit = $urandom_range(0, 19) == 0 ? $urandom_range(1, 4) : 200;
      solve_count++;
      send_request(REQ_START, $urandom, 1'b0, '0, has, r);
      for (k = 0; k < limit; k++) begin
         fv = func_at(longint'(signed'(r.point)), shape, root, slope, flip);
         send_request(REQ_VALUE, fv, 1'b0, '0, has, r);
         if (!has || r.finished)
            break;
      end
      // stray value, ignored when idle
      if ($urandom_range(0, 15) == 0)
         send_request(REQ_VALUE, $urandom, 1'b0, '0, has, r);
   endtask

   // random stalls on the result side, with quiet stretches too
   initial begin
      rsp_ready = 1'b0;
      forever begin
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 40)) @(posedge clock);
         rsp_ready <= 1'b0;
         repeat (pick_gap() + 1) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         result_count++;
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected result fin=%0d point=%h cnt=%0d st=%0d", $realtime,
                     rsp_finished, rsp_point, rsp_iteration_count, rsp_status);
            fail_count++;
         end else begin
            if (rsp_finished !== expected_q[0].finished) begin
               $display("%0t: finished expected %0d actual %0d", $realtime,
                        expected_q[0].finished, rsp_finished);
               fail_count++;
            end
            if (rsp_point !== expected_q[0].point) begin
               $display("%0t: point expected %h actual %h", $realtime,
                        expected_q[0].point, rsp_point);
               fail_count++;
            end
            if (rsp_iteration_count !== expected_q[0].count) begin
               $display("%0t: iteration_count expected %0d actual %0d", $realtime,
                        expected_q[0].count, rsp_iteration_count);
               fail_count++;
            end
            if (rsp_status !== expected_q[0].status) begin
               $display("%0t: status expected %0d actual %0d", $realtime,
                        expected_q[0].status, rsp_status);
               fail_count++;
            end
            void'(expected_q.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $realtime, idle_cycles);
         $display("tb_bracketed_root_brent_core NOT OK");
         $finish;
      end
   end

   initial begin
      stim_row_type rows[$];
      result_type   r;
      bit           has;
      int           i, p, goal;
      logic [30:0]  tol_set[6];
      logic [30:0]  it_set[6];

      req_valid = 1'b0; req_type = REQ_START; req_func_value = '0;
      csr_valid = 1'b0; csr_index = CSR_TOLERANCE; csr_data = '0;
      fail_count = 0; request_count = 0; result_count = 0; solve_count = 0;
      idle_cycles = 0;
      tol_reg = 1024; maxit_reg = 100;
      ph = PH_IDLE; steps = 0; bis_flag = 1'b1;
      ctr_pt = 0; best_pt = 0; prev_pt = 0; old_pt = 0; pend_pt = 0;
      ctr_val = 0; best_val = 0; prev_val = 0;
      reset = 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, reset settings
      rows.push_back('{REQ_VALUE, 32'h1234_5678, 1'b0, '0});    // ignored while idle
      rows.push_back('{REQ_START, 32'hffff_ffff, 1'b1, '{1'b0, 32'h0, 11'd0, 1'b0}});
      rows.push_back('{REQ_VALUE, 32'd5, 1'b1, '{1'b0, PT_ONE, 11'd0, 1'b0}});
      rows.push_back('{REQ_VALUE, 32'd7, 1'b1, '{1'b1, PT_NEG_ONE, 11'd0, 1'b1}});
      rows.push_back('{REQ_START, 32'h0, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h8000_0000, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h7fff_ffff, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0000_0001, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'hffff_ffff, 1'b0, '0});
      rows.push_back('{REQ_START, 32'h0, 1'b0, '0});             // abandon the solve
      rows.push_back('{REQ_START, 32'h0, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'hffff_0000, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0, 1'b1, '{1'b1, PT_ONE, 11'd0, 1'b0}});
      rows.push_back('{REQ_START, 32'h0, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0, 1'b0, '0});             // both endpoints zero
      rows.push_back('{REQ_START, 32'h0, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0001_0000, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'hffff_0000, 1'b0, '0});
      rows.push_back('{REQ_VALUE, 32'h0001_0000, 1'b0, '0});     // repeated value: secant
      rows.push_back('{REQ_VALUE, 32'h0001_0000, 1'b0, '0});
      for (i = 0; i < rows.size(); i++)
         send_request(rows[i].kind, rows[i].value, rows[i].typed, rows[i].res, has, r);
      wait_drained();

      // settings, the extremes among them
      tol_set = '{31'd0, 31'h4000_0000, 31'd5, 31'd0, 31'd1024, 31'd0};
      it_set  = '{31'd20, 31'd1023, 31'd0, 31'd1, 31'd100, 31'd0};
      tol_set[5] = $urandom_range(0, 1 << 20);
      it_set[5]  = $urandom_range(2, 60);
      goal = 0;
      for (p = 0; p < 6; p++) begin
         write_csr(CSR_TOLERANCE, tol_set[p]);
         write_csr(CSR_MAX_ITER, it_set[p]);
         goal += 115;
         while (request_count < goal)
            run_solve();
         wait_drained();
      end

      repeat (50) @(posedge clock);
      $display("Ran %0d solves, %0d requests, %0d results checked,", solve_count,
               request_count, result_count);
      $display("over six tolerance and iteration-limit settings.");
      if (fail_count == 0 && expected_q.size() == 0)
         $display("tb_bracketed_root_brent_core OK");
      else
         $display("tb_bracketed_root_brent_core NOT OK");
      $finish;
   end

endmodule

// ----- bracketed_root_brent_core.f -----
hdl/brd_pkg.sv
hdl/brd_div.sv
hdl/bracketed_root_brent_core.sv
verif/tb_bracketed_root_brent_core.sv
